// ----- rtl/core/ofs_pkg.sv -----
package ofs_pkg;

    localparam int NOW_W      = 63;
    localparam int TIME_W     = 64;
    localparam int PHASE_W    = 2;
    localparam int ALPHA_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [PHASE_W-1:0] t_phase_code;

    localparam t_phase_code PH_HIDDEN   = 2'd0;
    localparam t_phase_code PH_FADE_IN  = 2'd1;
    localparam t_phase_code PH_SHOW     = 2'd2;
    localparam t_phase_code PH_FADE_OUT = 2'd3;

    // phase and time left to the deadline, handed to the opacity pipeline
    typedef struct packed {
        t_phase_code       phase;
        logic [TIME_W-1:0] d;
    } t_ramp_req;

endpackage

// ----- rtl/core/ofs_in_if.sv -----
interface ofs_in_if import ofs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_ns;

    modport source (output valid, output now_ns, input ready);
    modport sink   (input valid, input now_ns, output ready);
endinterface

// ----- rtl/core/ofs_out_if.sv -----
interface ofs_out_if import ofs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] phase;
    logic               draw;
    logic [ALPHA_W-1:0] alpha;

    modport source (output valid, output phase, output draw, output alpha, input ready);
    modport sink   (input valid, input phase, input draw, input alpha, output ready);
endinterface

// ----- rtl/core/ofs_cfg_if.sv -----
interface ofs_cfg_if import ofs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/overlay_fade_sequencer.sv -----
// Overlay fade sequencer: one result per frame request, a new request can be taken every
// cycle while the output is not stalled and no configuration settle is under way.
// The phase and deadline update for a request is done combinationally from the input register,
// which is what keeps the rate at one per cycle; the opacity is then worked out in a five stage pipeline
// (saturate, reciprocal multiply, remainder check, correction, opacity select). After reset
// and after every configuration write to a listed register, requests are held off
// while durations are rescaled to nanoseconds and the show lengths are derived.
module overlay_fade_sequencer import ofs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ofs_cfg_if.sink   i_cfg,
    ofs_in_if.sink    i_req,
    ofs_out_if.source o_res
);

    localparam int NS_W  = 42;
    localparam int LEN_W = NS_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd5;

    localparam logic [1:0] POL_CUSTOM = 2'd1;
    localparam logic [1:0] POL_ALWAYS = 2'd2;

    localparam logic [1:0]      CFG_SETTLE = 2'd2;
    localparam logic [NS_W-1:0] NS_PER_US  = 42'd1000;

    typedef enum logic [3:0] {
        ST_HIDDEN   = 4'b0001,
        ST_FADE_IN  = 4'b0010,
        ST_SHOW     = 4'b0100,
        ST_FADE_OUT = 4'b1000
    } t_phase_st;

    logic [1:0]       r_policy;
    logic [NS_W-1:0]  r_start_ns, r_show_ns, r_fi_ns, r_fo_ns, r_iv_ns;
    logic [LEN_W-1:0] r_fades, r_first_len, r_later_len;
    logic [1:0]       r_busy;

    t_phase_st         r_phase, n_phase;
    logic [TIME_W-1:0] r_deadline, n_deadline;
    logic              r_first_pass, n_first;

    logic             r_s0_valid;
    logic [NOW_W-1:0] r_s0_now;
    logic             r_s1_valid;
    t_ramp_req        r_s1_req;

    logic              cfg_wr, cfg_hit;
    logic [NS_W-1:0]   cfg_ns;
    logic              s0_ready, s1_ready, pipe_ready, in_acc;
    logic [TIME_W-1:0] now64, dl_diff, s1_d;
    logic              held, dl_zero, c_adv;
    logic [LEN_W-1:0]  c_add;
    t_phase_code       c_code;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign cfg_hit     = cfg_wr && (i_cfg.index <= REG_INTERVAL);
    assign cfg_ns      = NS_W'(i_cfg.data) * NS_PER_US;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= '0;
            r_start_ns <= '0;
            r_show_ns  <= '0;
            r_fi_ns    <= '0;
            r_fo_ns    <= '0;
            r_iv_ns    <= '0;
            r_busy     <= CFG_SETTLE;
        end else begin
            if (cfg_hit) begin
                r_busy <= CFG_SETTLE;
            end else if (r_busy != 2'd0) begin
                r_busy <= r_busy - 2'd1;
            end
            if (cfg_wr) begin
                case (i_cfg.index)
                    REG_POLICY:   r_policy   <= i_cfg.data[1:0];
                    REG_START:    r_start_ns <= cfg_ns;
                    REG_SHOW:     r_show_ns  <= cfg_ns;
                    REG_FADE_IN:  r_fi_ns    <= cfg_ns;
                    REG_FADE_OUT: r_fo_ns    <= cfg_ns;
                    REG_INTERVAL: r_iv_ns    <= cfg_ns;
                    default:      ;
                endcase
            end
        end
    end

    // show length net of both fades, clamped at zero
    always_ff @(posedge i_clk) begin
        r_fades     <= LEN_W'(r_fi_ns) + LEN_W'(r_fo_ns);
        r_first_len <= (LEN_W'(r_start_ns) > r_fades) ? LEN_W'(r_start_ns) - r_fades : '0;
        r_later_len <= (LEN_W'(r_show_ns) > r_fades) ? LEN_W'(r_show_ns) - r_fades : '0;
    end

    assign s1_ready    = !r_s1_valid || pipe_ready;
    assign s0_ready    = !r_s0_valid || s1_ready;
    assign i_req.ready = s0_ready && (r_busy == 2'd0);
    assign in_acc      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_s0_now <= i_req.now_ns;
    end

    assign now64   = TIME_W'(r_s0_now);
    assign held    = now64 < r_deadline;
    assign dl_diff = r_deadline - now64;
    assign dl_zero = (r_deadline == '0);

    always_comb begin
        n_phase    = r_phase;
        n_first    = r_first_pass;
        n_deadline = r_deadline;
        c_add      = '0;
        c_adv      = 1'b0;
        case (r_policy)
            POL_CUSTOM: begin
                if (dl_zero) begin
                    n_phase = ST_FADE_IN;
                    n_first = 1'b1;
                    c_add   = LEN_W'(r_fi_ns);
                    c_adv   = 1'b1;
                end else if (!held) begin
                    c_adv = 1'b1;
                    case (r_phase)
                        ST_FADE_IN: begin
                            n_phase = ST_SHOW;
                            n_first = 1'b0;
                            c_add   = r_first_pass ? r_first_len : r_later_len;
                        end
                        ST_SHOW: begin
                            n_phase = ST_FADE_OUT;
                            c_add   = LEN_W'(r_fo_ns);
                        end
                        ST_FADE_OUT: begin
                            n_phase = ST_HIDDEN;
                            c_add   = LEN_W'(r_iv_ns);
                        end
                        default: begin
                            n_phase = ST_FADE_IN;
                            c_add   = LEN_W'(r_fi_ns);
                        end
                    endcase
                end
            end
            POL_ALWAYS: n_phase = ST_SHOW;
            default:    n_phase = ST_HIDDEN;
        endcase
        if (c_adv) n_deadline = now64 + TIME_W'(c_add);
        // after an advance the time left is exactly the added length
        s1_d = c_adv ? TIME_W'(c_add) : (held ? dl_diff : '0);
    end

    always_comb begin
        case (n_phase)
            ST_FADE_IN:  c_code = PH_FADE_IN;
            ST_SHOW:     c_code = PH_SHOW;
            ST_FADE_OUT: c_code = PH_FADE_OUT;
            default:     c_code = PH_HIDDEN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ST_HIDDEN;
            r_deadline   <= '0;
            r_first_pass <= 1'b1;
        end else if (cfg_hit) begin
            r_deadline   <= '0;
            r_first_pass <= 1'b1;
        end else if (r_s0_valid && s1_ready) begin
            r_phase      <= n_phase;
            r_deadline   <= n_deadline;
            r_first_pass <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_req.phase <= c_code;
            r_s1_req.d     <= s1_d;
        end
    end

    ofs_alpha_pipe u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (pipe_ready),
        .i_req   (r_s1_req),
        .o_res   (o_res)
    );

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_deadline == '0 && r_first_pass))
        else $error("register write did not restart the cycle");

    a_settle_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy != 2'd0) |-> !i_req.ready)
        else $error("request taken before durations settled");

    a_first_show_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_valid && s1_ready && !cfg_hit && r_policy == POL_CUSTOM && !dl_zero && !held
         && r_phase == ST_FADE_IN) |=> (!r_first_pass && r_phase == ST_SHOW))
        else $error("entering show did not end the first pass");

endmodule

// ----- rtl/core/ofs_alpha_pipe.sv -----
module ofs_alpha_pipe import ofs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_ramp_req i_req,
    ofs_out_if.source o_res
);

    localparam int DS_W      = 29;
    localparam int M_W       = 28;
    localparam int PROD_W    = DS_W + M_W;
    localparam int RECIP_SH  = 40;
    localparam int C_W       = 21;
    localparam int REM_W     = DS_W + 9;

    localparam logic [DS_W-1:0]    RAMP_NS   = 29'd500000000;
    // floor(2^40 * 65536 / 500000000)
    localparam logic [M_W-1:0]     RECIP_M   = 28'd144115188;
    // 500000000 / 256
    localparam logic [C_W-1:0]     DIV_C     = 21'd1953125;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    logic rdy2, rdy3, rdy4, rdy5, rdy6;
    logic r_v2, r_v3, r_v4, r_v5, r_v6;

    t_phase_code        r_s2_phase, r_s3_phase, r_s4_phase, r_s5_phase;
    logic [DS_W-1:0]    r_s2_ds, r_s3_ds, r_s4_ds;
    logic               r_s2_dzero, r_s3_dzero, r_s4_dzero, r_s5_dzero;
    logic [PROD_W-1:0]  r_s3_prod;
    logic [ALPHA_W-1:0] r_s4_q, r_s5_q;
    logic [REM_W-1:0]   r_s4_prod;

    t_phase_code        r_res_phase;
    logic               r_res_draw;
    logic [ALPHA_W-1:0] r_res_alpha;

    logic [ALPHA_W-1:0] q_est;
    logic [REM_W-1:0]   rem;
    logic               corr;
    logic [ALPHA_W-1:0] n_alpha;

    assign rdy6    = !r_v6 || o_res.ready;
    assign rdy5    = !r_v5 || rdy6;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (rdy2) r_v2 <= i_valid;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
        end
    end

    // saturate to the ramp length
    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_phase <= i_req.phase;
            r_s2_ds    <= (i_req.d > TIME_W'(RAMP_NS)) ? RAMP_NS : i_req.d[DS_W-1:0];
            r_s2_dzero <= (i_req.d == '0);
        end
    end

    // reciprocal multiply, estimate is exact or one low
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_phase <= r_s2_phase;
            r_s3_ds    <= r_s2_ds;
            r_s3_dzero <= r_s2_dzero;
            r_s3_prod  <= PROD_W'(r_s2_ds) * PROD_W'(RECIP_M);
        end
    end

    assign q_est = r_s3_prod[RECIP_SH +: ALPHA_W];

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_phase <= r_s3_phase;
            r_s4_ds    <= r_s3_ds;
            r_s4_dzero <= r_s3_dzero;
            r_s4_q     <= q_est;
            r_s4_prod  <= REM_W'(q_est) * REM_W'(DIV_C);
        end
    end

    // remainder check fixes the low estimate
    assign rem  = {1'b0, r_s4_ds, 8'd0} - r_s4_prod;
    assign corr = (rem >= REM_W'(DIV_C));

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_s5_phase <= r_s4_phase;
            r_s5_dzero <= r_s4_dzero;
            r_s5_q     <= r_s4_q + ALPHA_W'(corr);
        end
    end

    always_comb begin
        case (r_s5_phase)
            PH_HIDDEN:   n_alpha = '0;
            PH_FADE_IN:  n_alpha = ALPHA_ONE - r_s5_q;
            PH_FADE_OUT: n_alpha = r_s5_dzero ? ALPHA_ONE : r_s5_q;
            default:     n_alpha = ALPHA_ONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r_res_phase <= r_s5_phase;
            r_res_draw  <= (r_s5_phase != PH_HIDDEN);
            r_res_alpha <= n_alpha;
        end
    end

    assign o_res.valid = r_v6;
    assign o_res.phase = r_res_phase;
    assign o_res.draw  = r_res_draw;
    assign o_res.alpha = r_res_alpha;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> rem < (REM_W'(DIV_C) + REM_W'(DIV_C)))
        else $error("reciprocal estimate off by more than one");

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> r_s5_q <= ALPHA_ONE)
        else $error("ramp quotient above full opacity");

    a_hidden_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && r_res_phase == PH_HIDDEN) |-> (!r_res_draw && r_res_alpha == '0))
        else $error("hidden result drawn or not transparent");

endmodule

// ----- test/ofs_tb_pkg.sv -----
`timescale 1ns / 1ps

package ofs_tb_pkg;

    // register map of the configuration channel, the two spares decode to nothing
    typedef enum logic [2:0] {
        REG_POLICY     = 3'd0,
        REG_START_TIME = 3'd1,
        REG_SHOW_TIME  = 3'd2,
        REG_FADE_IN    = 3'd3,
        REG_FADE_OUT   = 3'd4,
        REG_INTERVAL   = 3'd5,
        REG_SPARE_6    = 3'd6,
        REG_SPARE_7    = 3'd7
    } t_reg_index;

    typedef enum logic [1:0] {
        POL_NEVER  = 2'd0,
        POL_CUSTOM = 2'd1,
        POL_ALWAYS = 2'd2,
        POL_UNUSED = 2'd3
    } t_policy;

endpackage

// ----- test/ofs_fade_checker.sv -----
`timescale 1ns / 1ps

module ofs_fade_checker import ofs_pkg::*; import ofs_tb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ofs_cfg_if   i_cfg,
    ofs_in_if    i_req,
    ofs_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [TIME_W-1:0] NS_PER_US  = 64'd1000;
    localparam logic [TIME_W-1:0] RAMP_NS    = 64'd500000000;
    localparam logic [TIME_W-1:0] ALPHA_FULL = 64'd65536;

    typedef struct packed {
        t_phase_code        phase;
        logic               draw;
        logic [ALPHA_W-1:0] alpha;
    } t_overlay_res;

    t_policy             policy_q;
    logic [31:0]         start_us;
    logic [31:0]         show_us;
    logic [31:0]         fade_in_us;
    logic [31:0]         fade_out_us;
    logic [31:0]         interval_us;
    t_phase_code         phase_q;
    logic [TIME_W-1:0]   deadline_q;
    logic                first_q;
    t_overlay_res        overlay_q[$];

    task automatic report_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic void apply_write(input t_reg_index idx, input logic [31:0] val);
        case (idx)
            REG_POLICY:     policy_q = t_policy'(val[1:0]);
            REG_START_TIME: start_us = val;
            REG_SHOW_TIME:  show_us = val;
            REG_FADE_IN:    fade_in_us = val;
            REG_FADE_OUT:   fade_out_us = val;
            REG_INTERVAL:   interval_us = val;
            default:        return;
        endcase
        // any mapped write restarts the cycle
        deadline_q = '0;
        first_q = 1'b1;
    endfunction

    function automatic t_phase_code advance_cycle(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] fi;
        logic [TIME_W-1:0] fo;
        logic [TIME_W-1:0] total;
        logic [TIME_W-1:0] fades;
        fi = TIME_W'(fade_in_us) * NS_PER_US;
        fo = TIME_W'(fade_out_us) * NS_PER_US;
        if (deadline_q == '0) begin
            first_q = 1'b1;
            deadline_q = now + fi;
            return PH_FADE_IN;
        end
        if (now < deadline_q)
            return phase_q;
        case (phase_q)
            PH_FADE_IN: begin
                total = TIME_W'(first_q ? start_us : show_us) * NS_PER_US;
                fades = fi + fo;
                // show shorter than both fades: leave the show phase at once
                deadline_q = (total > fades) ? now + (total - fades) : now;
                first_q = 1'b0;
                return PH_SHOW;
            end
            PH_SHOW: begin
                deadline_q = now + fo;
                return PH_FADE_OUT;
            end
            PH_FADE_OUT: begin
                deadline_q = now + TIME_W'(interval_us) * NS_PER_US;
                return PH_HIDDEN;
            end
            default: begin
                deadline_q = now + fi;
                return PH_FADE_IN;
            end
        endcase
    endfunction

    function automatic t_overlay_res predict_overlay(input logic [NOW_W-1:0] now_ns);
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] left;
        logic [TIME_W-1:0] ramp;
        t_phase_code       ph;
        t_overlay_res      res;
        now = TIME_W'(now_ns);
        case (policy_q)
            POL_CUSTOM: ph = advance_cycle(now);
            POL_ALWAYS: ph = PH_SHOW;
            default:    ph = PH_HIDDEN;
        endcase
        phase_q = ph;
        left = (deadline_q > now) ? deadline_q - now : '0;
        if (left > RAMP_NS)
            left = RAMP_NS;
        ramp = left * ALPHA_FULL / RAMP_NS;
        res.phase = ph;
        res.draw = (ph != PH_HIDDEN);
        case (ph)
            PH_HIDDEN:   res.alpha = '0;
            PH_FADE_IN:  res.alpha = ALPHA_W'(ALPHA_FULL - ramp);
            PH_FADE_OUT: res.alpha = (left == '0) ? ALPHA_W'(ALPHA_FULL) : ALPHA_W'(ramp);
            default:     res.alpha = ALPHA_W'(ALPHA_FULL);
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_overlay_res want;
        if (!i_rst_n) begin
            policy_q    = POL_NEVER;
            start_us    = '0;
            show_us     = '0;
            fade_in_us  = '0;
            fade_out_us = '0;
            interval_us = '0;
            phase_q     = PH_HIDDEN;
            deadline_q  = '0;
            first_q     = 1'b1;
            overlay_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                apply_write(t_reg_index'(i_cfg.index), i_cfg.data);
            if (i_req.valid && i_req.ready)
                overlay_q.push_back(predict_overlay(i_req.now_ns));
            if (i_res.valid && i_res.ready) begin
                if (overlay_q.size() == 0) begin
                    report_failure("result with no frame request outstanding");
                end else begin
                    want = overlay_q.pop_front();
                    if (i_res.phase !== want.phase)
                        report_failure($sformatf("phase expected %0d got %0d",
                                                 want.phase, i_res.phase));
                    if (i_res.draw !== want.draw)
                        report_failure($sformatf("draw expected %0d got %0d",
                                                 want.draw, i_res.draw));
                    if (i_res.alpha !== want.alpha)
                        report_failure($sformatf("alpha expected %0d got %0d",
                                                 want.alpha, i_res.alpha));
                end
            end
            o_pending <= overlay_q.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import ofs_pkg::*;
    import ofs_tb_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          FRAMES_PER_SET = 38;
    localparam int          SETS_PER_MODE  = 6;
    localparam logic [62:0] MS             = 63'd1000000;
    localparam logic [62:0] NOW_MAX        = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int frames_sent = 0;
    int settings_used = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int idle_tab[4] = '{0, 50, 0, 30};
    int stall_tab[4] = '{0, 0, 50, 30};
    logic [62:0] frame_time;

    ofs_cfg_if cfg_bus ();
    ofs_in_if  frame_bus ();
    ofs_out_if res_bus ();

    overlay_fade_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_req   (frame_bus),
        .o_res   (res_bus)
    );

    ofs_fade_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_bus),
        .i_req        (frame_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((cfg_bus.valid && cfg_bus.ready) || (frame_bus.valid && frame_bus.ready) ||
            (res_bus.valid && res_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", idle_cycles);
            $display("overlay_fade_sequencer verification failed");
            $finish;
        end
    end

    // returns once every predicted overlay has come back
    task automatic wait_idle();
        frame_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [31:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    task automatic send_frame(input logic [62:0] now);
        while ($urandom_range(99) < sender_idle_pct) begin
            frame_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        frame_bus.valid  <= 1'b1;
        frame_bus.now_ns <= now;
        do @(posedge i_clk); while (!frame_bus.ready);
        frames_sent++;
    endtask

    function automatic logic [31:0] pick_us(input int unsigned span_ms);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 12)
            return '1;
        if (r < 16)
            return $urandom;
        // whole milliseconds make exact deadline hits likely
        if (r < 60)
            return $urandom_range(0, span_ms) * 1000;
        return $urandom_range(0, span_ms * 1000);
    endfunction

    function automatic logic [31:0] pick_policy();
        int unsigned r;
        logic [31:0] v;
        r = $urandom_range(99);
        v = $urandom;
        if (r < 70)
            v[1:0] = POL_CUSTOM;
        else if (r < 80)
            v[1:0] = POL_NEVER;
        else if (r < 90)
            v[1:0] = POL_ALWAYS;
        else
            v[1:0] = POL_UNUSED;
        return v;
    endfunction

    function automatic logic [62:0] next_time(input logic [62:0] cur);
        int unsigned r;
        logic [62:0] back;
        r = $urandom_range(99);
        back = 63'($urandom_range(0, 2000)) * MS;
        if (r < 50)
            return cur + 63'($urandom_range(0, 400)) * MS;
        if (r < 72)
            return cur + 63'($urandom_range(0, 300000000));
        if (r < 80)
            return cur + 63'($urandom_range(0, 10000)) * MS;
        // time going backwards
        if (r < 86)
            return (cur > back) ? cur - back : '0;
        if (r < 91)
            return cur;
        if (r < 96)
            return 63'({$urandom, $urandom});
        return r[0] ? NOW_MAX : '0;
    endfunction

    task automatic program_random_setting();
        wait_idle();
        write_reg(REG_START_TIME, pick_us(3000));
        write_reg(REG_SHOW_TIME, pick_us(3000));
        write_reg(REG_FADE_IN, pick_us(800));
        write_reg(REG_FADE_OUT, pick_us(800));
        write_reg(REG_INTERVAL, pick_us(1500));
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
        write_reg(REG_POLICY, pick_policy());
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= REG_POLICY;
        cfg_bus.data     <= '0;
        frame_bus.valid  <= 1'b0;
        frame_bus.now_ns <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // policy never from reset, at both ends of the time range
        send_frame('0);
        send_frame(NOW_MAX);

        wait_idle();
        write_reg(REG_POLICY, 32'(POL_ALWAYS));
        cfg_bus.valid <= 1'b0;
        send_frame(5 * MS);

        // unused policy code with all upper data bits set
        wait_idle();
        write_reg(REG_POLICY, '1);
        cfg_bus.valid <= 1'b0;
        send_frame(6 * MS);

        // all durations zero: deadline lands on zero at time zero, empty show and fades
        wait_idle();
        write_reg(REG_START_TIME, '0);
        write_reg(REG_SHOW_TIME, '0);
        write_reg(REG_FADE_IN, '0);
        write_reg(REG_FADE_OUT, '0);
        write_reg(REG_INTERVAL, '0);
        write_reg(REG_POLICY, 32'(POL_CUSTOM));
        cfg_bus.valid <= 1'b0;
        settings_used++;
        send_frame('0);
        send_frame('0);
        repeat (5) send_frame(63'd10);

        // first show shorter than the two fades, later show long
        wait_idle();
        write_reg(REG_FADE_IN, 32'd400000);
        write_reg(REG_FADE_OUT, 32'd300000);
        write_reg(REG_START_TIME, 32'd500000);
        write_reg(REG_SHOW_TIME, 32'd2000000);
        write_reg(REG_INTERVAL, 32'd100000);
        cfg_bus.valid <= 1'b0;
        settings_used++;
        send_frame(1000 * MS);
        send_frame(1200 * MS);
        send_frame(1400 * MS);
        send_frame(1400 * MS);
        send_frame(1550 * MS);
        send_frame(1700 * MS);
        send_frame(1800 * MS);
        send_frame(2200 * MS);
        send_frame(1000 * MS);
        send_frame(3500 * MS);

        // longest fade-in near the top of the time range, spare index ignored
        wait_idle();
        write_reg(REG_FADE_IN, '1);
        write_reg(REG_SPARE_6, $urandom);
        cfg_bus.valid <= 1'b0;
        settings_used++;
        send_frame(NOW_MAX);
        send_frame(NOW_MAX - 63'd1);
        send_frame('0);

        frame_time = '0;
        for (int mode = 0; mode < 4; mode++) begin
            sender_idle_pct = idle_tab[mode];
            stall_pct = stall_tab[mode];
            for (int s = 0; s < SETS_PER_MODE; s++) begin
                program_random_setting();
                repeat (FRAMES_PER_SET) begin
                    frame_time = next_time(frame_time);
                    send_frame(frame_time);
                end
            end
        end

        sender_idle_pct = 0;
        stall_pct = 0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d frame requests over %0d register settings", frames_sent,
                 settings_used);
        $display("pacing: free-running, sender gaps, receiver stalls and both combined");
        if (fail_count == 0) begin
            $display("overlay_fade_sequencer verification clean");
        end else begin
            $display("overlay_fade_sequencer verification failed");
        end
        $finish;
    end

endmodule
